@@ rtl/core/wfg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait-for graph package
// Shared constants, payload types, state encoding and control structs for
// the wait-for graph cycle detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

  localparam int MAX_TXNS     = 64;
  localparam int SLOT_W       = $clog2(MAX_TXNS);
  localparam int CNT_W        = $clog2(MAX_TXNS + 1);
  localparam int NODE_COUNT_W = 7;

  typedef logic [MAX_TXNS-1:0] row_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EVAL,
    S_TAKE,
    S_RMW,
    S_Q_FIRST,
    S_Q_PICK,
    S_Q_OR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        waiting_node_id;
    logic [63:0]        waiting_txn_number;
    logic signed [63:0] waiting_stamp;
    logic [31:0]        blocking_node_id;
    logic [63:0]        blocking_txn_number;
    logic signed [63:0] blocking_stamp;
  } item_t;

  typedef struct packed {
    logic                    deadlocked;
    logic [1:0]              status;
    logic [NODE_COUNT_W-1:0] node_count;
  } result_t;

  typedef struct packed {
    logic [31:0]        node_id;
    logic [63:0]        txn_number;
    logic signed [63:0] stamp;
  } key_t;

  typedef struct packed {
    logic waiting;
    logic blocking;
  } key_hit_t;

  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    key_t  wr_key;
    slot_t rd_addr;
  } key_ctl_t;

  typedef struct packed {
    logic  clear_all;
    logic  wr_en;
    slot_t wr_addr;
    row_t  wr_row;
    slot_t rd_addr;
  } row_ctl_t;

endpackage

@@ rtl/core/wfg_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel that carries one graph operation per transfer.
// ----------------------------------------------------------------------------
interface wfg_in_if;
  logic           valid;
  logic           ready;
  wfg_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/wfg_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface wfg_out_if;
  logic             valid;
  logic             ready;
  wfg_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/wfg_key_tbl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transaction key table
// Slot-indexed key memory with a registered read port and the shared key
// comparator that checks one stored key against both probe keys per cycle.
// ----------------------------------------------------------------------------
module wfg_key_tbl (
  input  logic              clk,
  input  wfg_pkg::key_ctl_t ctl,
  input  wfg_pkg::key_t     probe_w,
  input  wfg_pkg::key_t     probe_b,
  output wfg_pkg::key_hit_t hit
);

  wfg_pkg::key_t mem [wfg_pkg::MAX_TXNS];
  wfg_pkg::key_t rd_key;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_key;
    end
    rd_key <= mem[ctl.rd_addr];
  end

  assign hit.waiting  = (rd_key == probe_w);
  assign hit.blocking = (rd_key == probe_b);

endmodule

@@ rtl/core/wfg_row_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait matrix row memory
// Adjacency rows in a memory with per-row valid bits; a row that was never
// written since reset or the last clear reads as all zero.
// ----------------------------------------------------------------------------
module wfg_row_mem (
  input  logic              clk,
  input  logic              rst,
  input  wfg_pkg::row_ctl_t ctl,
  output wfg_pkg::row_t     rd_row
);

  wfg_pkg::row_t mem [wfg_pkg::MAX_TXNS];
  wfg_pkg::row_t row_valid;
  wfg_pkg::row_t rd_data;
  logic          rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_row;
    end
    rd_data <= mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      rd_ok <= row_valid[ctl.rd_addr];
      if (ctl.clear_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_ok ? rd_data : '0;

endmodule

@@ rtl/core/wait_for_graph_cycle_detector.sv @@
`timescale 1ns / 1ps
// Clear and no-op go straight to the done state. Add edge and query first scan
// the key table over the slots in use (skipped when empty), then add edge
// allocates slots and updates one row, while query merges one row per reached slot.
// One item at a time: a new command is taken only once the last result has
// been placed in the result register, and a stall on the result channel holds it.
// Reset clears slot count, reach set, row valid bits and the result valid flag.
// ----------------------------------------------------------------------------
// Wait-for graph cycle detector
// Bounded wait-for graph of transactions with key lookup, edge insertion and
// deadlock query by reachability over the adjacency matrix.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detector (
  input logic        clk,
  input logic        rst,
  wfg_in_if.sink     cmd,
  wfg_out_if.source  res
);

  // The sequencer walks one slot per cycle through the key table to find the
  // waiting and blocking keys, then either allocates slots and does a
  // read-modify-write of one matrix row, or grows the reach set one matrix
  // row at a time until no unvisited reached slot remains.

  wfg_pkg::state_t  state;
  wfg_pkg::state_t  state_next;

  wfg_pkg::item_t   item;
  wfg_pkg::count_t  used;
  wfg_pkg::slot_t   scan_idx;
  logic             cmp_vld;
  wfg_pkg::slot_t   cmp_idx;
  logic             w_found;
  logic             b_found;
  wfg_pkg::slot_t   w_slot;
  wfg_pkg::slot_t   b_slot;
  wfg_pkg::row_t    reach;
  wfg_pkg::row_t    done_set;
  logic             res_dead;
  logic [1:0]       res_status;
  logic             out_valid;
  wfg_pkg::result_t out_data;

  wfg_pkg::key_t     w_key;
  wfg_pkg::key_t     b_key;
  wfg_pkg::key_hit_t hit;
  wfg_pkg::key_ctl_t key_ctl;
  wfg_pkg::row_ctl_t row_ctl;
  wfg_pkg::row_t     row_rd;
  wfg_pkg::row_t     pend;
  wfg_pkg::slot_t    pick;
  wfg_pkg::count_t   need;
  logic              same;
  logic              full;
  logic              scan_last;
  logic              accept;
  logic              out_free;

  // Lowest reached slot whose successors have not yet been merged.
  function automatic wfg_pkg::slot_t lowest_set(input wfg_pkg::row_t v);
    wfg_pkg::slot_t r;
    r = '0;
    for (int i = wfg_pkg::MAX_TXNS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = wfg_pkg::SLOT_W'(i);
      end
    end
    return r;
  endfunction

  assign w_key = '{item.waiting_node_id, item.waiting_txn_number, item.waiting_stamp};
  assign b_key = '{item.blocking_node_id, item.blocking_txn_number, item.blocking_stamp};

  assign same      = (w_key == b_key);
  assign need      = wfg_pkg::CNT_W'(!w_found) + wfg_pkg::CNT_W'(!b_found && !same);
  assign full      = ({1'b0, used} + {1'b0, need}) > (wfg_pkg::CNT_W + 1)'(wfg_pkg::MAX_TXNS);
  assign scan_last = (wfg_pkg::CNT_W'(scan_idx) == used - wfg_pkg::CNT_W'(1));
  assign pend      = reach & ~done_set;
  assign pick      = lowest_set(pend);

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !out_valid || res.ready;

  assign res.valid = out_valid;
  assign res.data  = out_data;

  wfg_key_tbl u_key_tbl (
    .clk     (clk),
    .ctl     (key_ctl),
    .probe_w (w_key),
    .probe_b (b_key),
    .hit     (hit)
  );

  wfg_row_mem u_row_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (row_ctl),
    .rd_row (row_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and memory control.
  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;

    key_ctl.wr_en   = 1'b0;
    key_ctl.wr_addr = used[wfg_pkg::SLOT_W-1:0];
    key_ctl.wr_key  = w_found ? b_key : w_key;
    key_ctl.rd_addr = scan_idx;

    row_ctl.clear_all = 1'b0;
    row_ctl.wr_en     = 1'b0;
    row_ctl.wr_addr   = w_slot;
    row_ctl.wr_row    = row_rd | (wfg_pkg::row_t'(1) << b_slot);
    row_ctl.rd_addr   = w_slot;

    unique case (state)
      wfg_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          unique case (cmd.data.op)
            wfg_pkg::OP_CLEAR: begin
              row_ctl.clear_all = 1'b1;
              state_next        = wfg_pkg::S_DONE;
            end
            wfg_pkg::OP_ADD_EDGE, wfg_pkg::OP_QUERY: begin
              state_next = (used == '0) ? wfg_pkg::S_EVAL : wfg_pkg::S_SCAN;
            end
            default: begin
              state_next = wfg_pkg::S_DONE;
            end
          endcase
        end
      end
      wfg_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = wfg_pkg::S_LAST;
        end
      end
      wfg_pkg::S_LAST: begin
        state_next = wfg_pkg::S_EVAL;
      end
      wfg_pkg::S_EVAL: begin
        if (item.op == wfg_pkg::OP_ADD_EDGE) begin
          state_next = full ? wfg_pkg::S_DONE : wfg_pkg::S_TAKE;
        end else begin
          state_next = w_found ? wfg_pkg::S_Q_FIRST : wfg_pkg::S_DONE;
        end
      end
      wfg_pkg::S_TAKE: begin
        key_ctl.wr_en = !w_found || (!b_found && !same);
        if (w_found && b_found) begin
          state_next = wfg_pkg::S_RMW;
        end
      end
      wfg_pkg::S_RMW: begin
        row_ctl.wr_en = 1'b1;
        state_next    = wfg_pkg::S_DONE;
      end
      wfg_pkg::S_Q_FIRST: begin
        state_next = wfg_pkg::S_Q_PICK;
      end
      wfg_pkg::S_Q_PICK: begin
        row_ctl.rd_addr = pick;
        state_next      = (pend == '0) ? wfg_pkg::S_DONE : wfg_pkg::S_Q_OR;
      end
      wfg_pkg::S_Q_OR: begin
        state_next = wfg_pkg::S_Q_PICK;
      end
      wfg_pkg::S_DONE: begin
        if (out_free) begin
          state_next = wfg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wfg_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath registers, updated by state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      used      <= '0;
      reach     <= '0;
      cmp_vld   <= 1'b0;
    end else begin
      // In the done state a new result replaces the one leaving, if any.
      if (res.valid && res.ready && (state != wfg_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end

      // The compare of a scanned slot lands in the cycle after its read.
      cmp_vld <= (state == wfg_pkg::S_SCAN);
      cmp_idx <= scan_idx;
      if (cmp_vld) begin
        if (hit.waiting && !w_found) begin
          w_found <= 1'b1;
          w_slot  <= cmp_idx;
        end
        if (hit.blocking && !b_found) begin
          b_found <= 1'b1;
          b_slot  <= cmp_idx;
        end
      end

      unique case (state)
        wfg_pkg::S_IDLE: begin
          if (accept) begin
            item       <= cmd.data;
            scan_idx   <= '0;
            w_found    <= 1'b0;
            b_found    <= 1'b0;
            res_dead   <= 1'b0;
            res_status <= wfg_pkg::ST_OK;
            if (cmd.data.op == wfg_pkg::OP_CLEAR) begin
              used  <= '0;
              reach <= '0;
            end
          end
        end
        wfg_pkg::S_SCAN: begin
          scan_idx <= scan_idx + wfg_pkg::SLOT_W'(1);
        end
        wfg_pkg::S_EVAL: begin
          done_set <= '0;
          if (item.op == wfg_pkg::OP_ADD_EDGE) begin
            if (full) begin
              res_status <= wfg_pkg::ST_FULL;
            end
          end else if (!w_found) begin
            reach      <= '0;
            res_status <= wfg_pkg::ST_UNKNOWN;
          end
        end
        wfg_pkg::S_TAKE: begin
          // Waiting key first, then the blocking key; an edge to itself
          // reuses the waiting slot.
          if (!w_found) begin
            w_found <= 1'b1;
            w_slot  <= used[wfg_pkg::SLOT_W-1:0];
            used    <= used + wfg_pkg::CNT_W'(1);
          end else if (!b_found) begin
            b_found <= 1'b1;
            if (same) begin
              b_slot <= w_slot;
            end else begin
              b_slot <= used[wfg_pkg::SLOT_W-1:0];
              used   <= used + wfg_pkg::CNT_W'(1);
            end
          end
        end
        wfg_pkg::S_Q_FIRST: begin
          reach <= row_rd;
        end
        wfg_pkg::S_Q_PICK: begin
          if (pend != '0) begin
            done_set[pick] <= 1'b1;
          end else begin
            res_dead <= reach[w_slot];
          end
        end
        wfg_pkg::S_Q_OR: begin
          reach <= reach | row_rd;
        end
        wfg_pkg::S_DONE: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.deadlocked <= res_dead;
            out_data.status     <= res_status;
            out_data.node_count <= wfg_pkg::NODE_COUNT_W'(used);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ tb/sv/tb_wait_for_graph_cycle_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait-for graph cycle detector testbench
// Drives clear, add-edge, query and no-op commands into the detector and
// compares every result against a behavioral graph model or a typed expected
// result. The run starts with a short table of hand-picked commands and then
// runs random episodes. Each builds a graph over a pool of transaction keys.
// ----------------------------------------------------------------------------
module tb_wait_for_graph_cycle_detector;
  import wfg_pkg::*;

  // Each side holds off in about this many cycles out of a hundred.
  localparam int IDLE_PCT     = 34;
  // A query merges every reached row after the key scan; this bounds one item.
  localparam int ITEM_CYCLES  = 3 * MAX_TXNS + 16;
  // No transfer on either channel for this long means the design is stuck.
  localparam int STALL_LIMIT  = 8 * (ITEM_CYCLES + 64);
  localparam int POOL_DEPTH   = 128;
  localparam int EPISODES     = 16;

  // Fixed keys for the directed table. The two stamp keys differ only in the
  // stamp, in every one of its bits, so they must never be confused.
  localparam key_t KEY_LOW       = '0;
  localparam key_t KEY_HIGH      = '1;
  localparam key_t KEY_MIN_STAMP = '{32'd1, 64'd0, 64'sh8000_0000_0000_0000};
  localparam key_t KEY_MAX_STAMP = '{32'd1, 64'd0, 64'sh7FFF_FFFF_FFFF_FFFF};

  typedef struct {
    item_t   cmd_item;
    bit      has_want;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  wfg_in_if  cmd ();
  wfg_out_if res ();

  wait_for_graph_cycle_detector u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the graph. Slots are taken in ascending order, so
  // a slot is in use exactly when its index is below graph_size.
  key_t graph_keys [MAX_TXNS];
  row_t graph_rows [MAX_TXNS];
  int   graph_size;

  // Results still owed by the design, oldest first.
  result_t  pending_results[$];
  result_t  head_result;
  dir_row_t dir_rows[$];

  int fail_count     = 0;
  int checked_count  = 0;
  int items_sent     = 0;
  int deadlock_count = 0;
  int full_count     = 0;
  int unknown_count  = 0;
  int peak_count     = 0;
  int quiet_cycles   = 0;

  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;

  function automatic item_t make_item(op_t op, key_t wk, key_t bk);
    return {op, wk, bk};
  endfunction

  function automatic key_t random_key();
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic dir_row_t dir_row(op_t op, key_t wk, key_t bk,
                                       bit has_want = 1'b0, result_t want = '0);
    dir_row_t r;
    r.cmd_item = make_item(op, wk, bk);
    r.has_want = has_want;
    r.want     = want;
    return r;
  endfunction

  function automatic int find_slot(key_t k);
    int i;
    for (i = 0; i < graph_size; i++) begin
      if (graph_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one command to the model graph and returns the result the
  // design must produce for it.
  function automatic result_t apply_graph_op(item_t it);
    result_t r;
    key_t    wk;
    key_t    bk;
    int      w;
    int      b;
    int      need;
    int      i;
    row_t    reach;
    row_t    prev;
    r  = '0;
    wk = '{it.waiting_node_id, it.waiting_txn_number, it.waiting_stamp};
    bk = '{it.blocking_node_id, it.blocking_txn_number, it.blocking_stamp};
    case (op_t'(it.op))
      OP_CLEAR: begin
        graph_size = 0;
        for (i = 0; i < MAX_TXNS; i++) graph_rows[i] = '0;
      end
      OP_ADD_EDGE: begin
        w    = find_slot(wk);
        b    = find_slot(bk);
        need = 0;
        if (w < 0) need++;
        if (b < 0 && wk != bk) need++;
        // The edge is all or nothing: if either new key does not fit,
        // no slot is taken at all.
        if (graph_size + need > MAX_TXNS) begin
          r.status = ST_FULL;
        end else begin
          if (w < 0) begin
            w = graph_size;
            graph_keys[w] = wk;
            graph_size++;
          end
          if (wk == bk) begin
            b = w;
          end else if (b < 0) begin
            b = graph_size;
            graph_keys[b] = bk;
            graph_size++;
          end
          graph_rows[w][b] = 1'b1;
        end
      end
      OP_QUERY: begin
        w = find_slot(wk);
        if (w < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          // Grow the set of slots reachable from the queried key until it
          // stops changing; the key is deadlocked if it reaches itself.
          reach = graph_rows[w];
          do begin
            prev = reach;
            for (i = 0; i < MAX_TXNS; i++) begin
              if (prev[i]) reach |= graph_rows[i];
            end
          end while (reach != prev);
          r.deadlocked = reach[w];
        end
      end
      default: begin
      end
    endcase
    r.node_count = NODE_COUNT_W'(graph_size);
    return r;
  endfunction

  // Presents one command and waits for its transfer. The valid line only
  // drops when a hold-off is chosen, so back-to-back commands keep it high.
  task automatic send_item(item_t it, bit has_want = 1'b0, result_t want = '0);
    result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= it;
    do @(posedge clk); while (!cmd.ready);
    predicted = apply_graph_op(it);
    pending_results.push_back(has_want ? want : predicted);
    items_sent++;
  endtask

  // One random episode: clear the graph, then mostly add edges and query
  // keys drawn from a pool. Some pool keys are near copies of others that
  // differ in a single bit, which stresses the key comparison.
  task automatic run_episode(int pool_n, int n_items, int add_pct);
    key_t                     pool [POOL_DEPTH];
    key_t                     k;
    logic [$bits(key_t)-1:0]  flip;
    item_t                    it;
    int                       i;
    int                       a;
    int                       b;
    int                       pick;
    for (i = 0; i < pool_n; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        flip = '0;
        flip[$urandom_range($bits(key_t) - 1)] = 1'b1;
        k = pool[$urandom_range(i - 1)] ^ flip;
      end else begin
        k = random_key();
      end
      pool[i] = k;
    end
    send_item(make_item(OP_CLEAR, random_key(), random_key()));
    repeat (n_items) begin
      a = $urandom_range(pool_n - 1);
      b = $urandom_range(pool_n - 1);
      if ($urandom_range(99) < add_pct) begin
        if ($urandom_range(19) == 0) b = a;
        it = make_item(OP_ADD_EDGE, pool[a], pool[b]);
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          it = make_item(OP_QUERY, pool[a], random_key());
        end else if (pick == 6) begin
          it = make_item(OP_QUERY, random_key(), random_key());
        end else if (pick == 7) begin
          it = make_item(OP_ADD_EDGE, pool[a], random_key());
        end else begin
          it = make_item(OP_NOP, random_key(), random_key());
        end
      end
      send_item(it);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // The receiving side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every result transfer is matched against the oldest pending result.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, deadlocked %0b status %0d node_count %0d",
                 $time, res.data.deadlocked, res.data.status, res.data.node_count);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("deadlocked", 8'(head_result.deadlocked), 8'(res.data.deadlocked));
        check_field("status", 8'(head_result.status), 8'(res.data.status));
        check_field("node_count", 8'(head_result.node_count), 8'(res.data.node_count));
        checked_count++;
        if (head_result.deadlocked) deadlock_count++;
        if (head_result.status == ST_FULL) full_count++;
        if (head_result.status == ST_UNKNOWN) unknown_count++;
        if (int'(head_result.node_count) > peak_count) begin
          peak_count = int'(head_result.node_count);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either channel ends
  // the run as a failure.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("tb_wait_for_graph_cycle_detector NOT OK");
      $finish;
    end
  end

  initial begin
    int ep;
    int i;
    cmd.valid = 1'b0;
    cmd.data  = '0;
    res.ready = 1'b0;
    rst       = 1'b1;
    graph_size = 0;
    for (i = 0; i < MAX_TXNS; i++) graph_rows[i] = '0;

    // Directed table. Rows with a typed result are the ones whose answer is
    // obvious: empty graph, clear, and the unknown-key error. The rest are
    // checked against the model.
    dir_rows.push_back(dir_row(OP_QUERY, KEY_LOW, KEY_HIGH, 1'b1, '{1'b0, ST_UNKNOWN, 7'd0}));
    dir_rows.push_back(dir_row(OP_NOP, KEY_HIGH, KEY_HIGH, 1'b1, '{1'b0, ST_OK, 7'd0}));
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_LOW, KEY_HIGH));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_LOW, KEY_LOW));
    // Closing the loop between the all-zero and all-one keys.
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_HIGH, KEY_LOW));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_HIGH, KEY_LOW));
    // The same edge again must leave the graph unchanged.
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_LOW, KEY_HIGH));
    // An edge from a key to itself takes one slot and is a cycle by itself.
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_MIN_STAMP, KEY_MIN_STAMP));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_MIN_STAMP, KEY_HIGH));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_MAX_STAMP, KEY_LOW, 1'b1,
                               '{1'b0, ST_UNKNOWN, 7'd3}));
    // A key that feeds into a cycle without being on it is not deadlocked.
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_MAX_STAMP, KEY_LOW));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_MAX_STAMP, KEY_HIGH));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_LOW, KEY_MAX_STAMP));
    dir_rows.push_back(dir_row(OP_NOP, KEY_LOW, KEY_LOW));
    dir_rows.push_back(dir_row(OP_CLEAR, KEY_HIGH, KEY_HIGH, 1'b1, '{1'b0, ST_OK, 7'd0}));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_HIGH, KEY_HIGH, 1'b1,
                               '{1'b0, ST_UNKNOWN, 7'd0}));
    dir_rows.push_back(dir_row(OP_ADD_EDGE, KEY_MAX_STAMP, KEY_MIN_STAMP));
    dir_rows.push_back(dir_row(OP_QUERY, KEY_MAX_STAMP, KEY_MIN_STAMP));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd_item, dir_rows[i].has_want, dir_rows[i].want);
    end

    // Random episodes. Most use a handful of keys so cycles form often; two
    // use a large pool with mostly edge insertions so the table fills up and
    // further edges get dropped. Two episodes run with no idling at all.
    for (ep = 0; ep < EPISODES; ep++) begin
      steady = (ep == 6 || ep == 7);
      if (ep == 4 || ep == 11) begin
        run_episode(100, 80, 85);
      end else begin
        run_episode($urandom_range(3, 10), $urandom_range(14, 22), 55);
      end
    end
    steady = 1'b0;
    cmd.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Let any stray extra result show up before the verdict.
    repeat (ITEM_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d results, peak table use %0d slots.",
             items_sent, checked_count, peak_count);
    $display("Seen %0d deadlocks, %0d dropped edges, %0d unknown-key queries.",
             deadlock_count, full_count, unknown_count);
    if (fail_count == 0) begin
      $display("tb_wait_for_graph_cycle_detector OK");
    end else begin
      $display("tb_wait_for_graph_cycle_detector NOT OK");
    end
    $finish;
  end

endmodule
